/* rtl/encoder_position_p_controller_defines.svh */
// ----------------------------------------------------------------------------
// Encoder position controller assertion macros
// Concurrent assertion wrappers used by the controller execution unit.
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_P_CONTROLLER_DEFINES_SVH
`define ENCODER_POSITION_P_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define EPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define EPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EPC_ASSERT(label, prop, msg)
`define EPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/epc_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder position controller package
// Shared types, codes and fixed-point constants.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int RUN_TICKS  = 1200;
  localparam int PWM_PERIOD = 1199;

  localparam int TICK_W     = 11;
  localparam int COUNT_W    = 32;
  localparam int CMP_W      = 11;
  localparam int DEG_W      = 10;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 16;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_GAIN   = 1'b1;

  localparam logic signed [19:0] RAD_PER_DEG_Q24   = 20'sd292818;
  localparam logic signed [15:0] RAD_PER_COUNT_Q24 = 16'sd29348;
  localparam logic [27:0]        VOLT_LIMIT_Q24    = 28'd201326592;

  typedef struct packed {
    logic [1:0] kind;
    logic       up;
  } cmd_t;

  typedef struct packed {
    logic               drive_valid;
    logic               direction;
    logic [CMP_W-1:0]   compare_value;
    logic [COUNT_W-1:0] position_count;
    logic               run_done;
  } result_t;

endpackage

/* rtl/epc_front.sv */
// ----------------------------------------------------------------------------
// Encoder position controller front end
// Classifies input items and decodes the quadrature step direction.
// ----------------------------------------------------------------------------
module epc_front import epc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] op,
  input  logic       phase_a,
  input  logic       phase_b,
  output cmd_t       cmd
);

  logic [1:0] last_phase;
  logic [1:0] now_phase;
  logic [1:0] fwd_phase;

  assign now_phase = {phase_a, phase_b};

  always_comb begin
    case (last_phase)
      2'b00:   fwd_phase = 2'b01;
      2'b01:   fwd_phase = 2'b11;
      2'b11:   fwd_phase = 2'b10;
      default: fwd_phase = 2'b00;
    endcase
  end

  always_comb begin
    cmd.up = (now_phase == fwd_phase);
    case (op)
      OP_START: cmd.kind = CMD_START;
      OP_EDGE:  cmd.kind = CMD_EDGE;
      OP_TICK:  cmd.kind = CMD_TICK;
      default:  cmd.kind = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase <= 2'b00;
    end else if (accept && op == OP_EDGE) begin
      last_phase <= now_phase;
    end
  end

endmodule

/* rtl/epc_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Encoder position controller command queue
// Short FIFO between the front end and the execution unit.
// ----------------------------------------------------------------------------
module epc_cmd_fifo import epc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t               entry [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   fill;

  assign full   = (fill == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty  = (fill == '0);
  assign rd_cmd = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/epc_back.sv */
// ----------------------------------------------------------------------------
// Encoder position controller execution unit
// Holds the count and run state and computes the proportional drive.
// ----------------------------------------------------------------------------
`include "encoder_position_p_controller_defines.svh"

module epc_back import epc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  input  logic                  cfg_we,
  input  logic                  cfg_sel,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  res_valid,
  input  logic                  res_take,
  output result_t               res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_ERR   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CLAMP = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [16:0] CMP_BASE = 17'(PWM_PERIOD + 1);

  logic [2:0]               state;
  logic signed [DEG_W-1:0]  target_deg;
  logic [GAIN_W-1:0]        gain;
  logic [COUNT_W-1:0]       pulse_count;
  logic [TICK_W-1:0]        tick_count;
  logic                     running;

  logic signed [29:0]       tgt_q;
  logic signed [46:0]       pos_q;
  logic signed [31:0]       err_q;
  logic signed [47:0]       u_q;
  logic [27:0]              mag_q;
  logic                     dir_q;

  logic                     out_free;
  logic                     res_load;
  logic [COUNT_W-1:0]       pulse_step;
  logic signed [29:0]       tgt_prod;
  logic signed [46:0]       pos_prod;
  logic signed [47:0]       diff;
  logic signed [31:0]       err_sat;
  logic signed [47:0]       u_prod;
  logic signed [47:0]       u_clamp;
  logic signed [47:0]       volt_pos;
  logic signed [47:0]       volt_neg;
  logic [34:0]              hund_prod;
  logic [CMP_W-1:0]         hund;
  logic [16:0]              cmp_full;
  logic [TICK_W-1:0]        tick_next;
  logic                     tick_done;

  assign out_free   = !res_valid || res_take;
  assign q_pop      = (state == S_IDLE) && !q_empty && out_free;
  assign res_load   = (q_pop && !(q_cmd.kind == CMD_TICK && running)) ||
                      (state == S_OUT && out_free);
  assign pulse_step = q_cmd.up ? pulse_count + 1'b1 : pulse_count - 1'b1;

  assign tgt_prod = target_deg * RAD_PER_DEG_Q24;
  assign pos_prod = $signed(pulse_count) * RAD_PER_COUNT_Q24;
  assign diff     = {{18{tgt_q[29]}}, tgt_q} - {pos_q[46], pos_q};
  assign u_prod   = err_q * $signed({1'b0, gain});
  assign volt_pos = $signed({20'd0, VOLT_LIMIT_Q24});
  assign volt_neg = -volt_pos;

  always_comb begin
    if (diff[47:31] == {17{1'b0}} || diff[47:31] == {17{1'b1}}) begin
      err_sat = diff[31:0];
    end else if (diff[47]) begin
      err_sat = {1'b1, {31{1'b0}}};
    end else begin
      err_sat = {1'b0, {31{1'b1}}};
    end
  end

  always_comb begin
    if (u_q >= volt_pos) begin
      u_clamp = volt_pos;
    end else if (u_q <= volt_neg) begin
      u_clamp = volt_neg;
    end else begin
      u_clamp = u_q;
    end
  end

  assign hund_prod = mag_q * 35'd100;
  assign hund      = hund_prod[34:24];
  assign cmp_full  = CMP_BASE - {6'd0, hund};
  assign tick_next = tick_count + 1'b1;
  assign tick_done = (tick_next == TICK_W'(RUN_TICKS));

  always_ff @(posedge clk) begin
    case (state)
      S_POS: begin
        tgt_q <= tgt_prod;
        pos_q <= pos_prod;
      end
      S_ERR: begin
        err_q <= err_sat;
      end
      S_MUL: begin
        u_q <= u_prod;
      end
      S_CLAMP: begin
        dir_q <= !(!u_clamp[47] && u_clamp != '0);
        mag_q <= u_clamp[47] ? 28'(-u_clamp) : u_clamp[27:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      target_deg  <= '0;
      gain        <= '0;
      pulse_count <= '0;
      tick_count  <= '0;
      running     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_sel)
          CFG_TARGET: target_deg <= cfg_wdata[DEG_W-1:0];
          CFG_GAIN:   gain       <= cfg_wdata[GAIN_W-1:0];
          default:    gain       <= gain;
        endcase
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            res.drive_valid   <= 1'b0;
            res.direction     <= 1'b0;
            res.compare_value <= '0;
            res.run_done      <= 1'b0;
            case (q_cmd.kind)
              CMD_START: begin
                pulse_count        <= '0;
                tick_count         <= '0;
                running            <= 1'b1;
                res.position_count <= '0;
              end
              CMD_EDGE: begin
                pulse_count        <= pulse_step;
                res.position_count <= pulse_step;
              end
              CMD_TICK: begin
                res.position_count <= pulse_count;
                if (running) begin
                  state <= S_POS;
                end
              end
              default: begin
                res.position_count <= pulse_count;
              end
            endcase
          end
        end
        S_POS:   state <= S_ERR;
        S_ERR:   state <= S_MUL;
        S_MUL:   state <= S_CLAMP;
        S_CLAMP: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            res.drive_valid    <= 1'b1;
            res.direction      <= dir_q;
            res.compare_value  <= cmp_full[CMP_W-1:0];
            res.position_count <= pulse_count;
            res.run_done       <= tick_done;
            tick_count         <= tick_next;
            if (tick_done) begin
              running <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `EPC_ASSERT_NEXT(a_pop_leads_on, q_pop, res_valid || state == S_POS, "popped command lost")
  `EPC_ASSERT(a_tick_bound, !running || tick_count < TICK_W'(RUN_TICKS), "tick count overrun")
  `EPC_ASSERT(a_done_has_drive, !(res_valid && res.run_done) || res.drive_valid, "done without drive")
  `EPC_ASSERT_NEXT(a_out_hold, state == S_OUT && !out_free, state == S_OUT && $stable(mag_q), "stall lost")

endmodule

/* rtl/encoder_position_p_controller.sv */
// ----------------------------------------------------------------------------
// Encoder position proportional controller
// Counts quadrature edges and drives a PWM from the position error on ticks.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when             payload
//  input     in         push && !full             op, phase_a, phase_b
//  result    out        pop && !empty             drive_valid .. run_done
//  config    in         cfg_valid && cfg_ready    cfg_index, cfg_data
//
// Start, edge, unknown and idle-tick items complete as the execution unit pops them.
// A tick during a run steps through the pos, err, mul, clamp and out states.
// A four-entry command queue lets input keep flowing while a tick is computed.
// Reset is synchronous and clears the count, run state and both registers.
// A result held in the output stalls the execution unit, and input once the queue fills.
// ----------------------------------------------------------------------------
module encoder_position_p_controller import epc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                op,
  input  logic                      phase_a,
  input  logic                      phase_b,
  output logic                      empty,
  input  logic                      pop,
  output logic                      drive_valid,
  output logic                      direction,
  output logic [CMP_W-1:0]          compare_value,
  output logic signed [COUNT_W-1:0] position_count,
  output logic                      run_done,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic    in_xfer;
  cmd_t    front_cmd;
  cmd_t    q_cmd;
  logic    q_empty;
  logic    q_pop;
  logic    res_valid;
  result_t res;

  assign in_xfer   = push && !full;
  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  epc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_xfer),
    .op      (op),
    .phase_a (phase_a),
    .phase_b (phase_b),
    .cmd     (front_cmd)
  );

  epc_cmd_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (in_xfer),
    .wr_cmd (front_cmd),
    .full   (full),
    .rd_en  (q_pop),
    .rd_cmd (q_cmd),
    .empty  (q_empty)
  );

  epc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .res_valid (res_valid),
    .res_take  (pop && res_valid),
    .res       (res)
  );

  assign drive_valid    = res.drive_valid;
  assign direction      = res.direction;
  assign compare_value  = res.compare_value;
  assign position_count = res.position_count;
  assign run_done       = res.run_done;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Encoder position controller testbench
// Drives start, edge and tick items through the input queue with random gaps,
// and pops results with random stalls. A directed table covers the extremes
// and the corner cases. Random phases follow, each with new register
// settings, and one of them is a full run to its final tick. Every result is
// checked field by field against a cycle-free controller model or a table row.
// ----------------------------------------------------------------------------
module testbench;
  import epc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint DEG_Q24 = 292818;
  localparam longint COUNT_Q24 = 29348;
  localparam longint VOLT_CAP = 12 * 2**24;
  localparam longint ERR_MAX = 2147483647;
  localparam longint ERR_MIN = -ERR_MAX - 1;

  typedef struct packed {
    logic            is_write;
    logic            reg_sel;
    logic [15:0]     data;
    logic [1:0]      kind;
    logic            a;
    logic            b;
    logic            typed;
    result_t         want;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic [1:0]                op = OP_START;
  logic                      phase_a = 1'b0;
  logic                      phase_b = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic                      drive_valid;
  logic                      direction;
  logic [CMP_W-1:0]          compare_value;
  logic signed [COUNT_W-1:0] position_count;
  logic                      run_done;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_index = CFG_TARGET;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  bit steady = 1'b0;
  int mismatches = 0;
  result_t pending_results[$];

  logic signed [DEG_W-1:0] target_deg = '0;
  logic [GAIN_W-1:0]       loop_gain = '0;
  logic [1:0]              enc_phase = 2'b00;
  logic [COUNT_W-1:0]      enc_count = '0;
  logic [TICK_W-1:0]       ticks_done = '0;
  logic                    run_active = 1'b0;

  encoder_position_p_controller dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .op(op), .phase_a(phase_a), .phase_b(phase_b),
    .empty(empty), .pop(pop),
    .drive_valid(drive_valid), .direction(direction), .compare_value(compare_value),
    .position_count(position_count), .run_done(run_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [1:0] gray_step(input logic [1:0] p, input bit forward);
    logic [1:0] fwd;
    logic [1:0] back;
    case (p)
      2'b00: begin fwd = 2'b01; back = 2'b10; end
      2'b01: begin fwd = 2'b11; back = 2'b00; end
      2'b11: begin fwd = 2'b10; back = 2'b01; end
      default: begin fwd = 2'b00; back = 2'b11; end
    endcase
    return forward ? fwd : back;
  endfunction

  function automatic result_t advance_controller(input logic [1:0] kind, input logic a,
                                                 input logic b);
    result_t r;
    longint err_q, drive_q, mag_q, hund, cmp_q;
    r = '0;
    case (kind)
      OP_START: begin
        enc_count = '0;
        ticks_done = '0;
        run_active = 1'b1;
      end
      OP_EDGE: begin
        if ({a, b} == gray_step(enc_phase, 1'b1)) enc_count = enc_count + 1;
        else enc_count = enc_count - 1;
        enc_phase = {a, b};
      end
      OP_TICK: begin
        if (run_active) begin
          err_q = longint'(target_deg) * DEG_Q24 - longint'($signed(enc_count)) * COUNT_Q24;
          if (err_q > ERR_MAX) err_q = ERR_MAX;
          if (err_q < ERR_MIN) err_q = ERR_MIN;
          drive_q = err_q * longint'(loop_gain);
          if (drive_q >= VOLT_CAP) drive_q = VOLT_CAP;
          if (drive_q <= -VOLT_CAP) drive_q = -VOLT_CAP;
          r.drive_valid = 1'b1;
          r.direction = (drive_q <= 0);
          mag_q = r.direction ? -drive_q : drive_q;
          hund = (mag_q * 100) >>> 24;
          cmp_q = PWM_PERIOD + 1 - hund;
          r.compare_value = cmp_q[CMP_W-1:0];
          ticks_done = ticks_done + 1'b1;
          if (ticks_done == RUN_TICKS) begin
            run_active = 1'b0;
            r.run_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.position_count = enc_count;
    return r;
  endfunction

  function automatic plan_row_t row_item(input logic [1:0] kind, input logic a, input logic b);
    plan_row_t r;
    r = '0;
    r.kind = kind;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic plan_row_t row_known(input logic [1:0] kind, input logic a, input logic b,
                                          input logic valid, input logic dir,
                                          input logic [CMP_W-1:0] cmp,
                                          input logic [COUNT_W-1:0] count, input logic done);
    plan_row_t r;
    r = row_item(kind, a, b);
    r.typed = 1'b1;
    r.want = '{valid, dir, cmp, count, done};
    return r;
  endfunction

  function automatic plan_row_t row_write(input logic sel, input logic [15:0] data);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_sel = sel;
    r.data = data;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic offer(input logic [1:0] kind, input logic a, input logic b,
                       input logic typed, input result_t want);
    result_t predicted;
    while (!steady && $urandom_range(0, 99) < 18) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= kind;
    phase_a <= a;
    phase_b <= b;
    do @(posedge clk); while (full);
    predicted = advance_controller(kind, a, b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_register(input logic sel, input logic [15:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    if (sel == CFG_TARGET) target_deg = data[DEG_W-1:0];
    else loop_gain = data[GAIN_W-1:0];
  endtask

  task automatic random_settings(input bit mild);
    logic [15:0] tdata;
    logic [15:0] gdata;
    tdata = 16'($urandom);
    case ($urandom_range(0, 3))
      0: tdata[9:0] = 10'h200;
      1: tdata[9:0] = 10'h1FF;
      default: ;
    endcase
    if (mild) gdata = 16'($urandom_range(1, 1000));
    else begin
      case ($urandom_range(0, 5))
        0: gdata = 16'h0000;
        1: gdata = 16'hFFFF;
        2: gdata = 16'($urandom_range(1, 16));
        3: gdata = 16'($urandom_range(17, 1000));
        default: gdata = 16'($urandom);
      endcase
    end
    write_register(CFG_TARGET, tdata, 1'b0);
    write_register(CFG_GAIN, gdata, 1'b1);
  endtask

  task automatic random_edge(input int drift);
    int pick;
    logic [1:0] next;
    pick = $urandom_range(0, 99);
    if (pick < 70) next = gray_step(enc_phase, $urandom_range(0, 99) < drift);
    else if (pick < 85) next = enc_phase;
    else if (pick < 95) next = gray_step(gray_step(enc_phase, 1'b1), 1'b1);
    else next = 2'($urandom);
    offer(OP_EDGE, next[1], next[0], 1'b0, '0);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with no item pending");
        end else begin
          want = pending_results.pop_front();
          if (drive_valid !== want.drive_valid)
            note_mismatch($sformatf("drive_valid expected %0d, got %0d",
                                    want.drive_valid, drive_valid));
          if (direction !== want.direction)
            note_mismatch($sformatf("direction expected %0d, got %0d",
                                    want.direction, direction));
          if (compare_value !== want.compare_value)
            note_mismatch($sformatf("compare_value expected %0d, got %0d",
                                    want.compare_value, compare_value));
          if (position_count !== want.position_count)
            note_mismatch($sformatf("position_count expected %0d, got %0d",
                                    $signed(want.position_count), position_count));
          if (run_done !== want.run_done)
            note_mismatch($sformatf("run_done expected %0d, got %0d",
                                    want.run_done, run_done));
        end
      end
      pop <= steady || ($urandom_range(0, 99) >= 18);
    end
  end

  initial begin : stimulus
    plan_row_t plan[];
    int n;
    int pick;
    int drift;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    plan = '{
      row_known(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 11'd0, 32'd0, 1'b0),
      row_known(OP_UNUSED, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0, 32'd0, 1'b0),
      row_known(OP_EDGE, 1'b0, 1'b1, 1'b0, 1'b0, 11'd0, 32'd1, 1'b0),
      row_known(OP_EDGE, 1'b0, 1'b1, 1'b0, 1'b0, 11'd0, 32'd0, 1'b0),
      row_item(OP_EDGE, 1'b1, 1'b1),
      row_item(OP_EDGE, 1'b1, 1'b0),
      row_item(OP_EDGE, 1'b0, 1'b0),
      row_item(OP_EDGE, 1'b1, 1'b0),
      row_item(OP_EDGE, 1'b0, 1'b1),
      row_known(OP_START, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0, 32'd0, 1'b0),
      row_known(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 11'd1200, 32'd0, 1'b0),
      row_write(CFG_TARGET, 16'd360),
      row_write(CFG_GAIN, 16'hFFFF),
      row_known(OP_START, 1'b1, 1'b1, 1'b0, 1'b0, 11'd0, 32'd0, 1'b0),
      row_known(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 11'd0, 32'd0, 1'b0),
      row_item(OP_EDGE, 1'b1, 1'b1),
      row_item(OP_TICK, 1'b0, 1'b1),
      row_write(CFG_TARGET, 16'hFE98),
      row_item(OP_TICK, 1'b1, 1'b0),
      row_write(CFG_TARGET, 16'd1),
      row_write(CFG_GAIN, 16'd1),
      row_known(OP_START, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0, 32'd0, 1'b0),
      row_known(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 11'd1199, 32'd0, 1'b0),
      row_write(CFG_TARGET, 16'h01FF),
      row_write(CFG_GAIN, 16'd700),
      row_item(OP_START, 1'b0, 1'b0),
      row_item(OP_TICK, 1'b0, 1'b0),
      row_write(CFG_TARGET, 16'hFE00),
      row_write(CFG_GAIN, 16'd3),
      row_item(OP_TICK, 1'b1, 1'b1),
      row_write(CFG_TARGET, 16'd0),
      row_write(CFG_GAIN, 16'd40000),
      row_item(OP_EDGE, 1'b1, 1'b0),
      row_item(OP_TICK, 1'b0, 1'b0),
      row_item(OP_EDGE, 1'b1, 1'b1),
      row_item(OP_TICK, 1'b0, 1'b0)
    };

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_results();
        write_register(plan[i].reg_sel, plan[i].data,
                       i + 1 >= plan.size() || !plan[i + 1].is_write);
      end else begin
        offer(plan[i].kind, plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    // One run carried through to its final tick.
    drain_results();
    random_settings(1'b1);
    drift = $urandom_range(30, 70);
    offer(OP_START, 1'($urandom), 1'($urandom), 1'b0, '0);
    n = 0;
    while (run_active) begin
      if (n == 200) steady <= 1'b1;
      if (n == 450) steady <= 1'b0;
      if (n == 700) drain_results();
      if ($urandom_range(0, 9) == 0) random_edge(drift);
      else offer(OP_TICK, 1'($urandom), 1'($urandom), 1'b0, '0);
      n++;
    end
    offer(OP_TICK, 1'($urandom), 1'($urandom), 1'b0, '0);
    repeat (3) random_edge(drift);

    repeat (6) begin
      drain_results();
      random_settings(1'b0);
      drift = $urandom_range(20, 80);
      if ($urandom_range(0, 3) != 0) offer(OP_START, 1'($urandom), 1'($urandom), 1'b0, '0);
      repeat (45) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) offer(OP_START, 1'($urandom), 1'($urandom), 1'b0, '0);
        else if (pick < 6) offer(OP_UNUSED, 1'($urandom), 1'($urandom), 1'b0, '0);
        else if (pick < 46) random_edge(drift);
        else offer(OP_TICK, 1'($urandom), 1'($urandom), 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
